// ===== rtl/ica_pkg.sv =====
// ----------------------------------------------------------------------------
// ica_pkg: shared types and codes for the integer calculator ALU
// Operation and status codes, request and result structs, sequencer states.
// ----------------------------------------------------------------------------
package ica_pkg;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_POW  = 3'd4,
        OP_GCD  = 3'd5,
        OP_FACT = 3'd6,
        OP_NONE = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIVZERO  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_INVALID  = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic signed [31:0] remainder;
        logic [1:0]         status;
    } rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_POW_MUL,
        S_POW_SQR,
        S_FACT,
        S_FIN,
        S_OUT
    } state_t;

    localparam logic [32:0] MAG_CAP = 33'h1_0000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MIN = 32'h8000_0000;

endpackage

// ===== rtl/integer_calculator_alu_core.sv =====
// ----------------------------------------------------------------------------
// integer_calculator_alu_core: iterative integer calculator
// Add, sub, mul, divmod, power, gcd and factorial on signed 32-bit operands.
// ----------------------------------------------------------------------------
//  channel | signals               | payload
//  req     | req_valid, req_ready  | ica_pkg::req_t
//  rsp     | rsp_valid, rsp_ready  | ica_pkg::rsp_t
//
// Add, sub and mul are computed in the decode state. Divide runs a restoring
// divider, one quotient bit a cycle. Power runs square-and-multiply on one
// shared saturating multiplier; factorial steps it up to 11 times. Gcd
// iterates remainder by the same divider, up to 45 divisions. One request in
// flight; req_ready is low until the result is taken. Reset clears control
// state only.
module integer_calculator_alu_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ica_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ica_pkg::rsp_t  rsp
);
    ica_pkg::state_t state_reg, state_next;
    logic [2:0]  kind_reg;
    logic [31:0] a_reg, b_reg;
    // divider: remainder, quotient/shift register, divisor
    logic [31:0] rm_reg, rm_next, q_reg, q_next, d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] acc_reg, acc_next, mag_reg, mag_next;
    logic [31:0] e_reg, e_next;
    logic [31:0] val_reg, val_next, rem_reg, rem_next;
    logic [1:0]  st_reg, st_next;
    logic [31:0] ga_reg, ga_next;
    logic        gcd_reg, gcd_next;

    logic [32:0] mx, my, mp;
    logic [32:0] trial;
    logic [31:0] rshift;
    logic [31:0] abs_a, abs_b;

    ica_satmul u_mul (.x(mx), .y(my), .p(mp));

    assign abs_a = a_reg[31] ? (32'd0 - a_reg) : a_reg;
    assign abs_b = b_reg[31] ? (32'd0 - b_reg) : b_reg;
    assign rshift = {rm_reg[30:0], q_reg[31]};
    assign trial = {1'b0, rshift} - {1'b0, d_reg};

    always_comb
    begin
        mx = acc_reg;
        my = mag_reg;
        case (state_reg)
            ica_pkg::S_POW_SQR: mx = mag_reg;
            ica_pkg::S_FACT:    my = {27'd0, cnt_reg};
            default:            mx = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ica_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ica_pkg::S_IDLE && req_valid)
        begin
            kind_reg <= req.kind;
            a_reg    <= req.operand_a;
            b_reg    <= req.operand_b;
        end
        rm_reg  <= rm_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        mag_reg <= mag_next;
        e_reg   <= e_next;
        val_reg <= val_next;
        rem_reg <= rem_next;
        st_reg  <= st_next;
        ga_reg  <= ga_next;
        gcd_reg <= gcd_next;
    end

    // next state and datapath
    always_comb
    begin
        state_next = state_reg;
        rm_next = rm_reg; q_next = q_reg; d_next = d_reg; cnt_next = cnt_reg;
        acc_next = acc_reg; mag_next = mag_reg; e_next = e_reg;
        val_next = val_reg; rem_next = rem_reg; st_next = st_reg;
        ga_next = ga_reg; gcd_next = gcd_reg;
        case (state_reg)
            ica_pkg::S_IDLE:
            begin
                if (req_valid)
                    state_next = ica_pkg::S_FIN;
            end
            ica_pkg::S_FIN:
            begin
                // decode the latched request and start the unit
                val_next = 32'd0;
                rem_next = 32'd0;
                st_next  = ica_pkg::ST_OK;
                gcd_next = 1'b0;
                state_next = ica_pkg::S_OUT;
                case (kind_reg)
                    ica_pkg::OP_ADD: val_next = a_reg + b_reg;
                    ica_pkg::OP_SUB: val_next = a_reg - b_reg;
                    ica_pkg::OP_MUL: val_next = 32'(a_reg * b_reg);
                    ica_pkg::OP_DIV:
                    begin
                        if (b_reg == 32'd0)
                            st_next = ica_pkg::ST_DIVZERO;
                        else if (a_reg == ica_pkg::NEG_MIN && b_reg == 32'hFFFF_FFFF)
                        begin
                            val_next = ica_pkg::POS_MAX;
                            st_next  = ica_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            rm_next = 32'd0; q_next = abs_a; d_next = abs_b;
                            cnt_next = 6'd32;
                            state_next = ica_pkg::S_DIV;
                        end
                    end
                    ica_pkg::OP_POW:
                    begin
                        if (b_reg[31])
                        begin
                            if (a_reg == 32'd0)
                                st_next = ica_pkg::ST_INVALID;
                            else if (a_reg == 32'd1)
                                val_next = 32'd1;
                            else if (a_reg == 32'hFFFF_FFFF)
                                val_next = b_reg[0] ? 32'hFFFF_FFFF : 32'd1;
                        end
                        else if (b_reg == 32'd0)
                            val_next = 32'd1;
                        else
                        begin
                            acc_next = 33'd1;
                            mag_next = {1'b0, abs_a};
                            e_next = b_reg;
                            state_next = ica_pkg::S_POW_MUL;
                        end
                    end
                    ica_pkg::OP_GCD:
                    begin
                        if (a_reg[31] || b_reg[31] || a_reg == 32'd0 || b_reg == 32'd0)
                            st_next = ica_pkg::ST_INVALID;
                        else
                        begin
                            gcd_next = 1'b1;
                            ga_next = b_reg;
                            rm_next = 32'd0; q_next = a_reg; d_next = b_reg;
                            cnt_next = 6'd32;
                            state_next = ica_pkg::S_DIV;
                        end
                    end
                    ica_pkg::OP_FACT:
                    begin
                        if (a_reg[31] || a_reg == 32'd0)
                            val_next = 32'd1;
                        else if (a_reg > 32'd12)
                        begin
                            val_next = ica_pkg::POS_MAX;
                            st_next  = ica_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            acc_next = 33'd1;
                            cnt_next = 6'd2;
                            state_next = ica_pkg::S_FACT;
                        end
                    end
                    default: st_next = ica_pkg::ST_INVALID;
                endcase
            end
            ica_pkg::S_DIV:
            begin
                if (cnt_reg != 6'd0)
                begin
                    cnt_next = cnt_reg - 6'd1;
                    if (!trial[32])
                    begin
                        rm_next = trial[31:0];
                        q_next = {q_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rm_next = rshift;
                        q_next = {q_reg[30:0], 1'b0};
                    end
                end
                else if (gcd_reg)
                begin
                    // advance Euclid: (a, b) <- (b, a mod b)
                    if (rm_reg == 32'd0)
                    begin
                        val_next = ga_reg;
                        state_next = ica_pkg::S_OUT;
                    end
                    else
                    begin
                        ga_next = rm_reg;
                        q_next = d_reg; d_next = rm_reg; rm_next = 32'd0;
                        cnt_next = 6'd32;
                    end
                end
                else
                begin
                    val_next = (a_reg[31] ^ b_reg[31]) ? (32'd0 - q_reg) : q_reg;
                    rem_next = a_reg[31] ? (32'd0 - rm_reg) : rm_reg;
                    state_next = ica_pkg::S_OUT;
                end
            end
            ica_pkg::S_POW_MUL:
            begin
                if (e_reg == 32'd0)
                begin
                    if (a_reg[31] && b_reg[0])
                    begin
                        if (acc_reg > {1'b0, ica_pkg::NEG_MIN})
                        begin
                            val_next = ica_pkg::NEG_MIN;
                            st_next = ica_pkg::ST_OVERFLOW;
                        end
                        else
                            val_next = 32'd0 - acc_reg[31:0];
                    end
                    else if (acc_reg > {1'b0, ica_pkg::POS_MAX})
                    begin
                        val_next = ica_pkg::POS_MAX;
                        st_next = ica_pkg::ST_OVERFLOW;
                    end
                    else
                        val_next = acc_reg[31:0];
                    state_next = ica_pkg::S_OUT;
                end
                else
                begin
                    if (e_reg[0])
                        acc_next = mp;
                    e_next = e_reg >> 1;
                    state_next = ica_pkg::S_POW_SQR;
                end
            end
            ica_pkg::S_POW_SQR:
            begin
                if (e_reg != 32'd0)
                    mag_next = mp;
                state_next = ica_pkg::S_POW_MUL;
            end
            ica_pkg::S_FACT:
            begin
                if ({26'd0, cnt_reg} > a_reg)
                begin
                    val_next = acc_reg[31:0];
                    state_next = ica_pkg::S_OUT;
                end
                else
                begin
                    acc_next = mp;
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ica_pkg::S_OUT:
            begin
                if (rsp_ready)
                    state_next = ica_pkg::S_IDLE;
            end
            default: state_next = ica_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready = (state_reg == ica_pkg::S_IDLE);
        rsp_valid = (state_reg == ica_pkg::S_OUT);
        rsp.value = val_reg;
        rsp.remainder = rem_reg;
        rsp.status = st_reg;
    end
endmodule

// ===== rtl/ica_satmul.sv =====
// ----------------------------------------------------------------------------
// ica_satmul: saturating 33x33 multiply
// Product of two magnitudes, clamped at 2^32; shared by power and factorial.
// ----------------------------------------------------------------------------
module ica_satmul (
    input  logic [32:0] x,
    input  logic [32:0] y,
    output logic [32:0] p
);
    logic [65:0] full;

    always_comb
    begin
        full = x * y;
        if (full > {33'd0, ica_pkg::MAG_CAP})
            p = ica_pkg::MAG_CAP;
        else
            p = full[32:0];
    end
endmodule
